// ===== sv/tie_pkg.sv =====
// package: item types, register codes and format codes of the tensor input encoder
`default_nettype none
package tie_pkg;

  typedef enum logic [1:0] {
    FMT_INT16 = 2'd0,
    FMT_FP16  = 2'd1,
    FMT_FP32  = 2'd2
  } fmt_e;

  typedef enum logic {
    REG_FORMAT_MODE = 1'b0,
    REG_FRAC_BITS   = 1'b1
  } reg_e;

  localparam int unsigned AddrWidth = 3;

  typedef struct packed {
    logic [31:0] value_bits;
    logic        last_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] coded_word;
    logic        last_out;
  } out_item_t;

endpackage
`default_nettype wire

// ===== sv/tensor_input_encoder_unit.sv =====
// top level: config registers, input register, encoder and result register
`default_nettype none
// Encodes one single-precision word per item as int16 fixed point, fp16 or
// fp32. An item is taken at every clock edge with start high; busy is always
// low, so one item per cycle is sustained. The result appears on result_o
// with result_valid_o high for exactly one cycle, after the item has passed
// the input register and then the result register; the receiver cannot
// stall. Write format_mode (address 0) and frac_bits (address 4) only while
// no item is in flight.
module tensor_input_encoder_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire tie_pkg::in_item_t                item_i,
  output tie_pkg::out_item_t                    result_o,
  output logic                                  result_valid_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [tie_pkg::AddrWidth-1:0]    paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  // config registers
  logic [1:0] format_mode_q;
  logic [3:0] frac_bits_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_mode_q <= 2'd0;
      frac_bits_q   <= 4'd0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        tie_pkg::REG_FORMAT_MODE: format_mode_q <= pwdata[1:0];
        tie_pkg::REG_FRAC_BITS:   frac_bits_q   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[2])
      tie_pkg::REG_FORMAT_MODE: prdata = {30'd0, format_mode_q};
      tie_pkg::REG_FRAC_BITS:   prdata = {28'd0, frac_bits_q};
      default:                  prdata = 32'd0;
    endcase
  end

  // input stage
  logic              in_vld_q;
  tie_pkg::in_item_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_vld_q <= 1'b0;
    else         in_vld_q <= start && !busy;
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) in_q <= item_i;
  end

  // encode between the two registers
  logic [31:0] coded_d;

  tie_encode u_encode (
    .value_i       (in_q.value_bits),
    .format_mode_i (format_mode_q),
    .frac_bits_i   (frac_bits_q),
    .coded_o       (coded_d)
  );

  // result stage
  logic               out_vld_q;
  tie_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else         out_vld_q <= in_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      out_q.coded_word <= coded_d;
      out_q.last_out   <= in_q.last_in;
    end
  end

  assign result_o       = out_q;
  assign result_valid_o = out_vld_q;

endmodule
`default_nettype wire

// ===== sv/tie_encode.sv =====
// combinational encoder: single precision to int16 fixed point, fp16 or fp32
`default_nettype none
module tie_encode (
  input  wire logic [31:0] value_i,
  input  wire logic [1:0]  format_mode_i,
  input  wire logic [3:0]  frac_bits_i,
  output logic      [31:0] coded_o
);

  logic        sgn;
  logic [7:0]  expo;
  logic [22:0] frac;

  assign sgn  = value_i[31];
  assign expo = value_i[30:23];
  assign frac = value_i[22:0];

  // int16 path
  logic [7:0]        e_eff;
  logic [23:0]       m_eff;
  logic signed [9:0] sh;
  logic [9:0]        rs;
  logic [4:0]        rs5;
  logic [23:0]       q;
  logic [24:0]       rem_mask;
  logic [24:0]       rem;
  logic [24:0]       half;
  logic              rnd_up;
  logic [24:0]       mag;
  logic              big;
  logic [15:0]       int_code;

  always_comb begin
    e_eff    = (expo == 8'd0) ? 8'd1 : expo;
    m_eff    = (expo == 8'd0) ? {1'b0, frac} : {1'b1, frac};
    sh       = $signed({2'b00, e_eff}) - 10'sd150 + $signed({6'd0, frac_bits_i});
    rs       = 10'd0 - sh;
    rs5      = rs[4:0];
    q        = m_eff >> rs5;
    rem_mask = (25'd1 << rs5) - 25'd1;
    rem      = {1'b0, m_eff} & rem_mask;
    half     = 25'd1 << (rs5 - 5'd1);
    rnd_up   = (rem > half) || ((rem == half) && q[0]);
    mag      = {1'b0, q} + {24'd0, rnd_up};
    big      = 1'b0;
    if (expo == 8'hFF) begin
      big = 1'b1;
      mag = 25'd0;
    end else if (sh >= 10'sd0) begin
      big = (m_eff != 24'd0);
      mag = 25'd0;
    end else if (rs >= 10'd26) begin
      mag = 25'd0;
    end
    if (sgn) begin
      if (big || mag > 25'd32768) int_code = 16'h8000;
      else                        int_code = 16'd0 - mag[15:0];
    end else begin
      if (big || mag > 25'd32767) int_code = 16'h7FFF;
      else                        int_code = mag[15:0];
    end
    // nan gives zero
    if (expo == 8'hFF && frac != 23'd0) int_code = 16'd0;
  end

  // fp16 path: round half up in magnitude
  logic signed [9:0] hex;
  logic [4:0]        sub_sh;
  logic [24:0]       sub_sum;
  logic [24:0]       sub_val;
  logic [23:0]       nrm_sum;
  logic [15:0]       nrm_val;
  logic [15:0]       half_code;

  always_comb begin
    hex     = $signed({2'b00, expo}) - 10'sd112;
    sub_sh  = 5'd14 - hex[4:0];
    sub_sum = {2'b01, frac} + (25'd1 << (sub_sh - 5'd1));
    sub_val = sub_sum >> sub_sh;
    nrm_sum = {1'b0, frac} + 24'h001000;
    nrm_val = {1'b0, hex[4:0], 10'd0} + {5'd0, nrm_sum[23:13]};
    if (hex < -10'sd10) begin
      half_code = {sgn, 15'd0};
    end else if (hex <= 10'sd0) begin
      half_code = {sgn, sub_val[14:0]};
    end else if (hex >= 10'sd31) begin
      half_code = {sgn, 15'h7C00};
    end else begin
      half_code = {sgn, nrm_val[14:0]};
    end
  end

  always_comb begin
    case (format_mode_i)
      tie_pkg::FMT_INT16: coded_o = {16'd0, int_code};
      tie_pkg::FMT_FP16:  coded_o = {16'd0, half_code};
      tie_pkg::FMT_FP32:  coded_o = value_i;
      default:            coded_o = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/tie_checker.sv =====
// port checker for the tensor input encoder, bound to the top level
`default_nettype none
module tie_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic result_valid_o,
  input wire logic pready
);

  // each accepted item gives a result after the input and result registers
  a_item_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 result_valid_o)
    else $error("accepted item produced no result");

  // no result without an accepted item that passed the input and result registers
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && $past(rst_ni, 2)) |-> $past(start && !busy, 2))
    else $error("result without an accepted item");

  // block never holds off items or register accesses
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && pready)
    else $error("busy or pready low");

endmodule

bind tensor_input_encoder_unit tie_checker u_tie_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .pready         (pready)
);
`default_nettype wire
